// ----- hw/rtl/bmp_stream_to_framebuffer_writes_core_defines.svh -----
// Assertion macros shared by the BMP stream decoder RTL.
`ifndef BMP_STREAM_TO_FRAMEBUFFER_WRITES_CORE_DEFINES_SVH
`define BMP_STREAM_TO_FRAMEBUFFER_WRITES_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BS2FB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bs2fb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BS2FB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bs2fb assertion failed");

`endif

// ----- hw/rtl/bs2fb_pkg.sv -----
// Types and constants shared by the BMP stream decoder modules.
package bs2fb_pkg;

    localparam int unsigned SCREEN_WIDTH      = 800;
    localparam int unsigned SCREEN_HEIGHT     = 480;
    localparam int unsigned PIXEL_DATA_OFFSET = 54;

    localparam logic [5:0] OFF_WIDTH  = 6'h12;
    localparam logic [5:0] OFF_HEIGHT = 6'h16;
    localparam logic [5:0] OFF_DEPTH  = 6'h1c;
    localparam logic [5:0] OFF_LAST   = 6'(PIXEL_DATA_OFFSET - 1);

    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_PIXEL  = 4'b0010,
        PH_PAD    = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [9:0] origin_x;
        logic [8:0] origin_y;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [9:0]  x;
        logic [8:0]  y;
        logic [31:0] color;
    } t_result;

endpackage

// ----- hw/rtl/bs2fb_cfg.sv -----
// Configuration register file with an APB-style access port.
module bs2fb_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output bs2fb_pkg::t_cfg      o_cfg
);
    import bs2fb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic c_write;

    assign c_write = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (c_write) begin
            case (paddr[2])
                REG_ORIGIN_X: n_cfg.origin_x = pwdata[9:0];
                REG_ORIGIN_Y: n_cfg.origin_y = pwdata[8:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ORIGIN_X: prdata = {22'd0, r_cfg.origin_x};
            REG_ORIGIN_Y: prdata = {23'd0, r_cfg.origin_y};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ----- hw/rtl/bs2fb_dec.sv -----
// Header parser and pixel assembler that holds the decoding state.
module bs2fb_dec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_sof,
    input  bs2fb_pkg::t_cfg      i_cfg,
    output logic                 o_res_valid,
    output bs2fb_pkg::t_result   o_res
);
    import bs2fb_pkg::*;

    t_phase      r_phase, n_phase, c_phase;
    logic [5:0]  r_off, n_off, c_off;
    logic [31:0] r_width, n_width, c_width;
    logic [31:0] r_height, n_height, c_height;
    logic [15:0] r_depth, n_depth, c_depth;
    logic [1:0]  r_pad_bytes, n_pad_bytes;
    logic [31:0] r_col, n_col;
    logic [31:0] r_w_m1, n_w_m1;
    logic [31:0] r_rows_left, n_rows_left;
    logic [1:0]  r_bip, n_bip;
    logic [1:0]  r_pad_cnt, n_pad_cnt;
    logic [23:0] r_partial, n_partial;
    logic [32:0] c_sx;
    logic [32:0] c_sy;
    logic [1:0]  c_last;
    logic [1:0]  c_neg_low;
    logic [2:0]  c_pad_next;

    // A start flag restarts the header parse with this byte as byte zero.
    always_comb begin
        c_phase  = i_sof ? PH_HEADER : r_phase;
        c_off    = i_sof ? 6'd0 : r_off;
        c_width  = i_sof ? 32'd0 : r_width;
        c_height = i_sof ? 32'd0 : r_height;
        c_depth  = i_sof ? 16'd0 : r_depth;
    end

    assign c_sx       = 33'(i_cfg.origin_x) + 33'(r_col);
    assign c_sy       = 33'(i_cfg.origin_y) + 33'(r_rows_left);
    assign c_last     = (r_depth == DEPTH_32) ? 2'd3 : 2'd2;
    assign c_neg_low  = ~c_width[1:0] + 2'd1;
    assign c_pad_next = 3'(r_pad_cnt) + 3'd1;

    always_comb begin
        n_phase     = c_phase;
        n_off       = c_off;
        n_width     = c_width;
        n_height    = c_height;
        n_depth     = c_depth;
        n_pad_bytes = r_pad_bytes;
        n_col       = r_col;
        n_w_m1      = r_w_m1;
        n_rows_left = r_rows_left;
        n_bip       = r_bip;
        n_pad_cnt   = r_pad_cnt;
        n_partial   = r_partial;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (c_phase)
            PH_HEADER: begin
                case (c_off)
                    OFF_WIDTH:           n_width[7:0]    = i_byte;
                    OFF_WIDTH + 6'd1:    n_width[15:8]   = i_byte;
                    OFF_WIDTH + 6'd2:    n_width[23:16]  = i_byte;
                    OFF_WIDTH + 6'd3:    n_width[31:24]  = i_byte;
                    OFF_HEIGHT:          n_height[7:0]   = i_byte;
                    OFF_HEIGHT + 6'd1:   n_height[15:8]  = i_byte;
                    OFF_HEIGHT + 6'd2:   n_height[23:16] = i_byte;
                    OFF_HEIGHT + 6'd3:   n_height[31:24] = i_byte;
                    OFF_DEPTH:           n_depth[7:0]    = i_byte;
                    OFF_DEPTH + 6'd1:    n_depth[15:8]   = i_byte;
                    default:             n_width         = c_width;
                endcase

                if (c_off == OFF_DEPTH + 6'd1 && n_depth != DEPTH_24
                        && n_depth != DEPTH_32) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    n_phase     = PH_DONE;
                end else if (c_off >= OFF_LAST) begin
                    if (c_width == 32'd0 || c_height == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        // One less than the magnitude: ~v for negative values.
                        n_w_m1      = c_width[31] ? ~c_width : c_width - 32'd1;
                        n_rows_left = c_height[31] ? ~c_height : c_height - 32'd1;
                        n_pad_bytes = (c_depth == DEPTH_24)
                                      ? (c_width[31] ? c_neg_low : c_width[1:0]) : 2'd0;
                        n_col       = '0;
                        n_bip       = '0;
                        n_pad_cnt   = '0;
                        n_phase     = PH_PIXEL;
                    end
                end else begin
                    n_off = c_off + 6'd1;
                end
            end
            PH_PIXEL: begin
                if (r_bip < c_last) begin
                    case (r_bip)
                        2'd0:    n_partial[7:0]   = i_byte;
                        2'd1:    n_partial[15:8]  = i_byte;
                        default: n_partial[23:16] = i_byte;
                    endcase
                    n_bip = r_bip + 2'd1;
                end else begin
                    o_res.kind  = KIND_PIXEL;
                    o_res.x     = c_sx[9:0];
                    o_res.y     = c_sy[8:0];
                    o_res.color = (r_depth == DEPTH_32) ? {i_byte, r_partial}
                                                        : {8'd0, i_byte, r_partial[15:0]};
                    o_res_valid = (c_sx < 33'(SCREEN_WIDTH)) && (c_sy < 33'(SCREEN_HEIGHT));
                    n_bip       = '0;
                    if (r_col == r_w_m1) begin
                        n_col = '0;
                        if (r_rows_left == 32'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_rows_left = r_rows_left - 32'd1;
                            if (r_pad_bytes != 2'd0) begin
                                n_pad_cnt = '0;
                                n_phase   = PH_PAD;
                            end
                        end
                    end else begin
                        n_col = r_col + 32'd1;
                    end
                end
            end
            PH_PAD: begin
                if (c_pad_next >= 3'(r_pad_bytes)) begin
                    n_pad_cnt = '0;
                    n_phase   = PH_PIXEL;
                end else begin
                    n_pad_cnt = c_pad_next[1:0];
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_off       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_depth     <= '0;
            r_pad_bytes <= '0;
            r_col       <= '0;
            r_w_m1      <= '0;
            r_rows_left <= '0;
            r_bip       <= '0;
            r_pad_cnt   <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_off       <= n_off;
            r_width     <= n_width;
            r_height    <= n_height;
            r_depth     <= n_depth;
            r_pad_bytes <= n_pad_bytes;
            r_col       <= n_col;
            r_w_m1      <= n_w_m1;
            r_rows_left <= n_rows_left;
            r_bip       <= n_bip;
            r_pad_cnt   <= n_pad_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_partial <= n_partial;
        end
    end

endmodule

// ----- hw/rtl/bmp_stream_to_framebuffer_writes_core.sv -----
// Top level of the BMP byte stream to framebuffer write decoder.
// Path: an accepted byte waits in the input register, and its result is then registered in the result register.
// Throughput: one byte per cycle while the result register is not stalled, set by the input and result register pair.
// A stalled result register holds its word while the input side keeps one more byte.
// Reset is synchronous and active low; it clears the decoding state but the partial pixel bytes, and both origins.
`include "bmp_stream_to_framebuffer_writes_core_defines.svh"

module bmp_stream_to_framebuffer_writes_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [9:0] screen_x, [18:10] screen_y, [50:19] pixel_color
    output logic        m_axis_tuser,   // [0] result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bs2fb_pkg::*;

    t_cfg       c_cfg;
    t_result    c_res;
    t_result    r_out;
    logic       c_res_valid;
    logic       c_step;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sof;
    logic       r_out_valid;

    assign c_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || c_step;

    bs2fb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (c_cfg)
    );

    bs2fb_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (c_step),
        .i_byte      (r_in_byte),
        .i_sof       (r_in_sof),
        .i_cfg       (c_cfg),
        .o_res_valid (c_res_valid),
        .o_res       (c_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (c_step) begin
                r_in_valid <= 1'b0;
            end
            if (c_step) begin
                r_out_valid <= c_res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_sof  <= s_axis_tuser;
        end
        if (c_step && c_res_valid) begin
            r_out <= c_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.color, r_out.y, r_out.x};

    `BS2FB_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid)
    `BS2FB_ASSERT_SAME(a_error_zero, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_ERROR, m_axis_tdata == 56'd0)
    `BS2FB_ASSERT_SAME(a_pixel_on_screen, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_PIXEL, 32'(r_out.x) < SCREEN_WIDTH && 32'(r_out.y) < SCREEN_HEIGHT)

endmodule

// ----- tb/sv/tb_bmp_stream_to_framebuffer_writes_core.sv -----
// Self-checking testbench for the BMP byte stream to framebuffer write decoder.
module tb_bmp_stream_to_framebuffer_writes_core;
    import bs2fb_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int RANDOM_MIN     = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WHOLE_FILE     = 32'h7fff_ffff;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmp_stream_to_framebuffer_writes_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Decoder state mirrored by the predictor.
    t_phase      dec_phase;
    logic [5:0]  hdr_off;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] img_depth;
    logic [1:0]  pad_len;
    logic [1:0]  pad_cnt;
    logic [1:0]  byte_idx;
    logic [31:0] pix_col;
    logic [31:0] pix_row;
    logic [23:0] pix_acc;
    logic [9:0]  cfg_x;
    logic [8:0]  cfg_y;

    t_result     pending_writes[$];
    t_result     head_write;
    logic [7:0]  bmp_bytes[$];

    int  mismatches     = 0;
    int  bytes_sent     = 0;
    int  pixels_seen    = 0;
    int  errors_seen    = 0;
    int  config_writes  = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    bit  long_hold_req  = 1'b0;
    bit  src_idle_en    = 1'b0;
    bit  sink_idle_en   = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] abs_dim(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        case (fill)
            FILL_ZEROS: return 8'h00;
            FILL_ONES:  return 8'hff;
            default:    return 8'($urandom);
        endcase
    endfunction

    task automatic clear_decoder();
        dec_phase = PH_HEADER;
        hdr_off   = '0;
        img_w     = '0;
        img_h     = '0;
        img_depth = '0;
        pad_len   = '0;
        pad_cnt   = '0;
        byte_idx  = '0;
        pix_col   = '0;
        pix_row   = '0;
        pix_acc   = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [5:0]      off;
        logic [31:0]     aw;
        logic [31:0]     ah;
        logic [31:0]     span;
        logic [1:0]      last_idx;
        logic [31:0]     color;
        longint unsigned sx;
        longint unsigned sy;
        t_result         w;
        if (sof) clear_decoder();
        aw = abs_dim(img_w);
        ah = abs_dim(img_h);
        case (dec_phase)
            PH_HEADER: begin
                off = hdr_off;
                if (off >= OFF_WIDTH && off <= OFF_WIDTH + 3)
                    img_w |= {24'd0, b} << (8 * (off - OFF_WIDTH));
                else if (off >= OFF_HEIGHT && off <= OFF_HEIGHT + 3)
                    img_h |= {24'd0, b} << (8 * (off - OFF_HEIGHT));
                else if (off == OFF_DEPTH || off == OFF_DEPTH + 1)
                    img_depth |= {8'd0, b} << (8 * (off - OFF_DEPTH));
                if (off == OFF_DEPTH + 1 && img_depth != DEPTH_24 && img_depth != DEPTH_32) begin
                    w = '0;
                    w.kind = KIND_ERROR;
                    pending_writes.push_back(w);
                    dec_phase = PH_DONE;
                end else if (off >= OFF_LAST) begin
                    aw = abs_dim(img_w);
                    ah = abs_dim(img_h);
                    if (aw == 0 || ah == 0) begin
                        dec_phase = PH_DONE;
                    end else begin
                        span = aw * 32'd3;
                        pad_len = (img_depth == DEPTH_24) ? (2'd0 - span[1:0]) : 2'd0;
                        dec_phase = PH_PIXEL;
                    end
                end else begin
                    hdr_off = off + 6'd1;
                end
            end
            PH_PIXEL: begin
                last_idx = (img_depth == DEPTH_32) ? 2'd3 : 2'd2;
                if (byte_idx < last_idx) begin
                    pix_acc |= {16'd0, b} << (8 * byte_idx);
                    byte_idx++;
                end else begin
                    color = (img_depth == DEPTH_32) ? {b, pix_acc} : {8'd0, b, pix_acc[15:0]};
                    sx = cfg_x;
                    sx = sx + pix_col;
                    sy = cfg_y;
                    sy = sy + ah - 1 - pix_row;
                    if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT) begin
                        w.kind  = KIND_PIXEL;
                        w.x     = sx[9:0];
                        w.y     = sy[8:0];
                        w.color = color;
                        pending_writes.push_back(w);
                    end
                    byte_idx = '0;
                    pix_acc  = '0;
                    pix_col++;
                    if (pix_col >= aw) begin
                        pix_col = '0;
                        pix_row++;
                        if (pix_row >= ah) begin
                            dec_phase = PH_DONE;
                        end else if (pad_len != 0) begin
                            pad_cnt   = '0;
                            dec_phase = PH_PAD;
                        end
                    end
                end
            end
            PH_PAD: begin
                pad_cnt++;
                if (pad_cnt >= pad_len) begin
                    pad_cnt   = '0;
                    dec_phase = PH_PIXEL;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b, sof);
        bytes_sent++;
    endtask

    task automatic send_bmp(input bit with_sof);
        foreach (bmp_bytes[i]) send_byte(bmp_bytes[i], with_sof && (i == 0));
    endtask

    task automatic build_bmp(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bpp_code, input int pix_cap,
                             input int trail, input int fill);
        longint unsigned rows;
        longint unsigned cols;
        longint unsigned r;
        longint unsigned c;
        int              bpp;
        int              pad;
        int              n;
        bmp_bytes.delete();
        for (int i = 0; i < PIXEL_DATA_OFFSET; i++) bmp_bytes.push_back(8'($urandom));
        bmp_bytes[0] = 8'h42;
        bmp_bytes[1] = 8'h4d;
        for (int i = 0; i < 4; i++) begin
            bmp_bytes[OFF_WIDTH + i]  = w[8*i +: 8];
            bmp_bytes[OFF_HEIGHT + i] = h[8*i +: 8];
        end
        bmp_bytes[OFF_DEPTH]     = bpp_code[7:0];
        bmp_bytes[OFF_DEPTH + 1] = bpp_code[15:8];
        rows = abs_dim(h);
        cols = abs_dim(w);
        bpp  = (bpp_code == DEPTH_32) ? 4 : 3;
        pad  = (bpp_code == DEPTH_32) ? 0 : int'((4 - (cols * 3) % 4) % 4);
        n    = 0;
        for (r = 0; r < rows && n < pix_cap; r++) begin
            for (c = 0; c < cols && n < pix_cap; c++) begin
                repeat (bpp) bmp_bytes.push_back(fill_byte(fill));
                n += bpp;
            end
            repeat (pad) bmp_bytes.push_back(8'($urandom));
            n += pad;
        end
        repeat (trail) bmp_bytes.push_back(8'($urandom));
    endtask

    task automatic settle_decoder();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_origin(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_ORIGIN_X) cfg_x = value[9:0];
        else cfg_y = value[8:0];
        want = (idx == REG_ORIGIN_X) ? {22'd0, cfg_x} : {23'd0, cfg_y};
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata: expected %h, actual %h", want, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        config_writes++;
    endtask

    task automatic set_origin(input logic [31:0] x, input logic [31:0] y);
        settle_decoder();
        write_origin(REG_ORIGIN_X, x);
        write_origin(REG_ORIGIN_Y, y);
    endtask

    function automatic logic [31:0] rand_origin(input int screen, input int field_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, screen - 1);
        if (r < 70) return $urandom_range(screen - 10, screen - 1);
        if (r < 85) return $urandom_range(0, 5);
        return $urandom_range(screen, field_max);
    endfunction

    task automatic test_headerless_start();
        build_bmp(3, 2, DEPTH_24, WHOLE_FILE, 2, FILL_RANDOM);
        send_bmp(1'b0);
    endtask

    task automatic test_depth_errors();
        set_origin(0, 0);
        build_bmp(2, 2, 16'd16, WHOLE_FILE, 3, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(2, 2, 16'd8, WHOLE_FILE, 0, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(2, 2, 16'd0, 0, 4, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(2, 2, 16'h0118, WHOLE_FILE, 0, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(2, 2, 16'hffff, 0, 2, FILL_RANDOM);
        send_bmp(1'b1);
    endtask

    task automatic test_signed_dims();
        set_origin(10, 10);
        build_bmp(-3, -2, DEPTH_24, WHOLE_FILE, 1, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(32'h8000_0000, 1, DEPTH_32, 40, 0, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(1, 32'h8000_0000, DEPTH_24, 30, 0, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(32'hffff_ffff, 32'hffff_ffff, DEPTH_32, WHOLE_FILE, 2, FILL_RANDOM);
        send_bmp(1'b1);
    endtask

    task automatic test_empty_images();
        build_bmp(0, 3, DEPTH_24, WHOLE_FILE, 5, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(4, 0, DEPTH_32, WHOLE_FILE, 5, FILL_RANDOM);
        send_bmp(1'b1);
    endtask

    task automatic test_origin_edges();
        set_origin(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
        build_bmp(3, 3, DEPTH_32, WHOLE_FILE, 0, FILL_ONES);
        send_bmp(1'b1);
        set_origin(SCREEN_WIDTH - 5, SCREEN_HEIGHT - 4);
        build_bmp(6, 5, DEPTH_24, WHOLE_FILE, 0, FILL_ZEROS);
        send_bmp(1'b1);
        set_origin(32'hffff_ffff, 32'hffff_ffff);
        build_bmp(2, 2, DEPTH_32, WHOLE_FILE, 0, FILL_RANDOM);
        send_bmp(1'b1);
        set_origin(0, 0);
        build_bmp(5, 2, DEPTH_24, WHOLE_FILE, 0, FILL_ONES);
        send_bmp(1'b1);
    endtask

    task automatic test_restart_midfile();
        build_bmp(4, 3, DEPTH_24, WHOLE_FILE, 0, FILL_RANDOM);
        bmp_bytes = bmp_bytes[0:19];
        send_bmp(1'b1);
        build_bmp(4, 3, DEPTH_24, 7, 0, FILL_RANDOM);
        send_bmp(1'b1);
        build_bmp(2, 2, DEPTH_32, WHOLE_FILE, 0, FILL_RANDOM);
        send_bmp(1'b1);
    endtask

    task automatic test_backpressure();
        set_origin(100, 100);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        build_bmp(8, 4, DEPTH_32, WHOLE_FILE, 0, FILL_RANDOM);
        long_hold_req = 1'b1;
        send_bmp(1'b1);
        settle_decoder();
    endtask

    task automatic test_random_traffic();
        int          target;
        int          kind;
        int          w;
        int          h;
        int          cut;
        int          fill;
        logic [31:0] sw;
        logic [31:0] sh;
        logic [15:0] dp;
        bit          with_sof;
        target = (bytes_sent + RANDOM_MIN > ITEM_TARGET) ? bytes_sent + RANDOM_MIN
                                                         : ITEM_TARGET;
        while (bytes_sent < target) begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                set_origin(rand_origin(SCREEN_WIDTH, 1023) | ($urandom << 10),
                           rand_origin(SCREEN_HEIGHT, 511) | ($urandom << 9));
            kind = $urandom_range(0, 99);
            dp   = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
            if ($urandom_range(0, 4) == 0) begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 5);
            end
            sw = ($urandom_range(0, 4) == 0) ? -w : w;
            sh = ($urandom_range(0, 4) == 0) ? -h : h;
            fill = ($urandom_range(0, 9) != 0) ? FILL_RANDOM : $urandom_range(FILL_ZEROS, FILL_ONES);
            with_sof = ($urandom_range(0, 19) != 0);
            if (kind < 68) begin
                build_bmp(sw, sh, dp, WHOLE_FILE, $urandom_range(0, 6), fill);
            end else if (kind < 78) begin
                do begin
                    dp = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
                end while (dp == DEPTH_24 || dp == DEPTH_32);
                build_bmp(sw, sh, dp, $urandom_range(0, 12), $urandom_range(0, 6), FILL_RANDOM);
            end else if (kind < 88) begin
                build_bmp(sw, sh, dp, WHOLE_FILE, 0, fill);
                cut = $urandom_range(1, bmp_bytes.size() - 1);
                bmp_bytes = bmp_bytes[0:cut-1];
            end else if (kind < 94) begin
                bmp_bytes.delete();
                repeat ($urandom_range(5, 40)) bmp_bytes.push_back(8'($urandom));
                with_sof = ($urandom_range(0, 1) != 0);
            end else begin
                if ($urandom_range(0, 1)) sw = 0;
                else sh = 0;
                build_bmp(sw, sh, dp, WHOLE_FILE, $urandom_range(0, 6), FILL_RANDOM);
            end
            send_bmp(with_sof);
        end
    endtask

    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else if (sink_idle_en && $urandom_range(0, 99) < 25) begin
            m_axis_tready = 1'b0;
            hold_left = idle_len() - 1;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                $error("result word with nothing pending: tuser %b tdata %h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                head_write = pending_writes.pop_front();
                if (m_axis_tuser !== head_write.kind) begin
                    $error("result_kind: expected %b, actual %b", head_write.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[9:0] !== head_write.x) begin
                    $error("screen_x: expected %0d, actual %0d", head_write.x, m_axis_tdata[9:0]);
                    mismatches++;
                end
                if (m_axis_tdata[18:10] !== head_write.y) begin
                    $error("screen_y: expected %0d, actual %0d", head_write.y,
                           m_axis_tdata[18:10]);
                    mismatches++;
                end
                if (m_axis_tdata[50:19] !== head_write.color) begin
                    $error("pixel_color: expected %h, actual %h", head_write.color,
                           m_axis_tdata[50:19]);
                    mismatches++;
                end
                if (head_write.kind == KIND_ERROR) errors_seen++;
                else pixels_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        clear_decoder();
        cfg_x = '0;
        cfg_y = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_headerless_start();
        test_depth_errors();
        test_signed_dims();
        test_empty_images();
        test_origin_edges();
        test_restart_midfile();
        test_backpressure();
        test_random_traffic();
        settle_decoder();

        $display("Sent %0d input words across %0d register writes.", bytes_sent, config_writes);
        $display("Checked %0d pixel writes and %0d depth errors.", pixels_seen, errors_seen);
        if (mismatches == 0 && pending_writes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
